### rtl/core/isqs_pkg.sv
// ----------------------------------------------------------------------------
// isqs_pkg
// Shared types and codes for the indexed sequence store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isqs_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LENGTH_W = 9;

  localparam logic [DATA_W-1:0] ERR_VALUE = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_READ   = 3'd3,
    REQ_WRITE  = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_INDEX = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // What every cell does with its word this cycle
  typedef enum logic [2:0] {
    K_NONE,
    K_APPEND,
    K_INSERT,
    K_REMOVE,
    K_WRITE
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  snap;   // copy words into the fetch chain
    logic  shift;  // move the fetch chain one cell towards the head
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

### rtl/core/isqs_cell.sv
// ----------------------------------------------------------------------------
// isqs_cell
// One position of the sequence: holds its word and a fetch-chain stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isqs_cell #(
  parameter int unsigned POS = 0,
  parameter int unsigned PW  = 9
) (
  input  wire                          clk,
  input  isqs_pkg::cmd_t               cmd,
  input  wire  [PW-1:0]                pos,
  input  wire  [isqs_pkg::DATA_W-1:0]  value,
  input  wire  [isqs_pkg::DATA_W-1:0]  left,
  input  wire  [isqs_pkg::DATA_W-1:0]  right,
  input  wire  [isqs_pkg::DATA_W-1:0]  carry_in,
  output logic [isqs_pkg::DATA_W-1:0]  data,
  output logic [isqs_pkg::DATA_W-1:0]  carry
);

  localparam logic [PW-1:0] MY_POS = PW'(POS);

  logic [isqs_pkg::DATA_W-1:0] data_next;
  logic [isqs_pkg::DATA_W-1:0] carry_next;

  always_comb begin
    data_next = data;
    unique case (cmd.kind)
      isqs_pkg::K_APPEND, isqs_pkg::K_WRITE: begin
        if (MY_POS == pos) data_next = value;
      end
      isqs_pkg::K_INSERT: begin
        if (MY_POS == pos)     data_next = value;
        else if (MY_POS > pos) data_next = left;
      end
      isqs_pkg::K_REMOVE: begin
        if (MY_POS >= pos) data_next = right;
      end
      default: data_next = data;
    endcase
  end

  // snapshot takes the word before this cycle's update
  always_comb begin
    carry_next = carry;
    if (cmd.snap)       carry_next = data;
    else if (cmd.shift) carry_next = carry_in;
  end

  always_ff @(posedge clk) begin
    data  <= data_next;
    carry <= carry_next;
  end

endmodule

`default_nettype wire

### rtl/core/indexed_sequence_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// Ordered sequence of signed words in a row of cells; append, insert,
// remove, read and overwrite by position, one result per item.
// ----------------------------------------------------------------------------
// Results: append, insert, overwrite and all errors give their result in the
//   cycle after acceptance; read and remove first walk the fetched word
//   along the cell row towards the head, one cell a cycle.
// Throughput: one item per cycle for non-fetching items while out_stall is
//   low; a read or remove holds off new items until its result is shown.
// Reset: synchronous, clears the length and control state; cell words are
//   left as they are and are never read until written.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [isqs_pkg::REQ_W-1:0]           req_type,
  input  wire  [isqs_pkg::INDEX_W-1:0]         index,
  input  wire  signed [isqs_pkg::DATA_W-1:0]   value_in,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [isqs_pkg::DATA_W-1:0]   value_out,
  output logic [isqs_pkg::STATUS_W-1:0]        status,
  output logic [isqs_pkg::LENGTH_W-1:0]        length_out
);

  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (PW > isqs_pkg::INDEX_W) ? PW : isqs_pkg::INDEX_W;
  localparam logic [PW-1:0] FULL_LEN = PW'(DEPTH);

  isqs_pkg::state_t state, state_next;

  logic [PW-1:0]                  len, len_next;
  logic [isqs_pkg::INDEX_W-1:0]   count, count_next;
  logic [isqs_pkg::DATA_W-1:0]    res_value;
  isqs_pkg::status_t              res_status;
  logic [isqs_pkg::LENGTH_W-1:0]  res_len;

  logic                           accept;
  logic                           can_accept;
  logic                           fetch;
  isqs_pkg::kind_t                kind;
  logic [PW-1:0]                  pos;
  logic [PW-1:0]                  len_new;
  logic [isqs_pkg::DATA_W-1:0]    dec_value;
  isqs_pkg::status_t              dec_status;
  logic [CW-1:0]                  idx_w;
  logic [CW-1:0]                  len_w;
  isqs_pkg::cmd_t                 cmd;

  logic [isqs_pkg::DATA_W-1:0]    cell_data  [DEPTH];
  logic [isqs_pkg::DATA_W-1:0]    cell_carry [DEPTH];

  assign accept = in_valid && can_accept;
  assign idx_w  = CW'(index);
  assign len_w  = CW'(len);

  // Request decode against the current length
  always_comb begin
    kind       = isqs_pkg::K_NONE;
    fetch      = 1'b0;
    dec_status = isqs_pkg::ST_OK;
    dec_value  = '0;
    len_new    = len;
    pos        = len;
    priority if (req_type > isqs_pkg::REQ_WRITE) begin
      dec_status = isqs_pkg::ST_INDEX;
      dec_value  = isqs_pkg::ERR_VALUE;
    end else if (req_type == isqs_pkg::REQ_APPEND ||
                 (req_type == isqs_pkg::REQ_INSERT && len == '0)) begin
      if (len >= FULL_LEN) begin
        dec_status = isqs_pkg::ST_FULL;
        dec_value  = isqs_pkg::ERR_VALUE;
      end else begin
        kind    = isqs_pkg::K_APPEND;
        len_new = len + 1'b1;
      end
    end else if (req_type == isqs_pkg::REQ_INSERT) begin
      if (idx_w >= len_w) begin
        dec_status = isqs_pkg::ST_INDEX;
        dec_value  = isqs_pkg::ERR_VALUE;
      end else if (len >= FULL_LEN) begin
        dec_status = isqs_pkg::ST_FULL;
        dec_value  = isqs_pkg::ERR_VALUE;
      end else begin
        kind    = isqs_pkg::K_INSERT;
        pos     = PW'(index);
        len_new = len + 1'b1;
      end
    end else if (len == '0) begin
      dec_status = isqs_pkg::ST_EMPTY;
      dec_value  = isqs_pkg::ERR_VALUE;
    end else if (idx_w >= len_w) begin
      dec_status = isqs_pkg::ST_INDEX;
      dec_value  = isqs_pkg::ERR_VALUE;
    end else begin
      pos = PW'(index);
      unique case (req_type)
        isqs_pkg::REQ_REMOVE: begin
          kind    = isqs_pkg::K_REMOVE;
          fetch   = 1'b1;
          len_new = len - 1'b1;
        end
        isqs_pkg::REQ_READ: fetch = 1'b1;
        default:            kind = isqs_pkg::K_WRITE;
      endcase
    end
  end

  always_comb begin
    cmd.kind  = accept ? kind : isqs_pkg::K_NONE;
    cmd.snap  = accept;
    cmd.shift = (state == isqs_pkg::S_WALK) && (count != '0);
  end

  // Cell row, head at position zero
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [isqs_pkg::DATA_W-1:0] left_w;
    logic [isqs_pkg::DATA_W-1:0] right_w;
    logic [isqs_pkg::DATA_W-1:0] cin_w;

    if (k == 0) begin : g_head
      assign left_w = cell_data[k];
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_tail
      assign right_w = cell_data[k];
      assign cin_w   = cell_carry[k];
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
      assign cin_w   = cell_carry[k+1];
    end

    isqs_cell #(
      .POS (k),
      .PW  (PW)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos),
      .value    (value_in),
      .left     (left_w),
      .right    (right_w),
      .carry_in (cin_w),
      .data     (cell_data[k]),
      .carry    (cell_carry[k])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    if (accept) begin
      state_next = fetch ? isqs_pkg::S_WALK : isqs_pkg::S_OUT;
    end else begin
      unique case (state)
        isqs_pkg::S_WALK: if (count == '0) state_next = isqs_pkg::S_OUT;
        isqs_pkg::S_OUT:  if (!out_stall) state_next = isqs_pkg::S_IDLE;
        default:          state_next = state;
      endcase
    end
  end

  // Handshake outputs
  always_comb begin
    can_accept = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      isqs_pkg::S_IDLE: can_accept = 1'b1;
      isqs_pkg::S_OUT: begin
        out_valid  = 1'b1;
        can_accept = !out_stall;
      end
      default: can_accept = 1'b0;
    endcase
  end

  assign in_stall = !can_accept;

  always_comb begin
    len_next   = accept ? len_new : len;
    count_next = count;
    if (accept)             count_next = index;
    else if (cmd.shift)     count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isqs_pkg::S_IDLE;
      len   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (accept) begin
      res_value  <= dec_value;
      res_status <= dec_status;
      res_len    <= isqs_pkg::LENGTH_W'(len_new);
    end else if (state == isqs_pkg::S_WALK && count == '0) begin
      res_value <= cell_carry[0];
    end
  end

  assign value_out  = res_value;
  assign status     = res_status;
  assign length_out = res_len;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= FULL_LEN)
    else $error("length beyond depth");

  a_len_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(len))
    else $error("length changed without an item");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !fetch) |=> out_valid)
    else $error("non-fetching item gave no result next cycle");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == isqs_pkg::ST_FULL) |->
      length_out == isqs_pkg::LENGTH_W'(DEPTH))
    else $error("full status with short length");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == isqs_pkg::ST_EMPTY) |-> length_out == '0)
    else $error("empty status with nonzero length");

endmodule

`default_nettype wire
